### hdl/htpl_pkg.sv
// ----------------------------------------------------------------------------
// htpl_pkg: shared definitions for the hash table probe lookup
// Table size, index and counter widths, and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package htpl_pkg;

  localparam int SLOTS = 128;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_FIND  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // An input request is taken this cycle.
    logic probe_rd;  // Read the slot at the current probe index.
    logic set_hit;   // Record the value read as a match.
    logic step;      // Move the probe index back by one slot.
    logic load_out;  // Copy the finished result into the output registers.
  } htpl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_find;   // The offered request is a find.
    logic key_zero;  // The offered key is zero.
    logic hit;       // The slot just read holds the key searched for.
    logic empty;     // The slot just read is empty.
    logic last;      // Every slot has been examined.
  } htpl_stat_t;

endpackage

### hdl/htpl_ctrl.sv
// ----------------------------------------------------------------------------
// htpl_ctrl: sequencer for the hash table probe lookup
// Steps a request through accept, probe read, compare and result hand-off.
// ----------------------------------------------------------------------------
module htpl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  htpl_pkg::htpl_stat_t stat,
  output htpl_pkg::htpl_cmd_t  cmd
);
  import htpl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PROBE = 4'b0010,
    S_CHECK = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.in_find && !stat.key_zero) begin
            state_nxt = S_PROBE;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_PROBE: begin
        cmd.probe_rd = 1'b1;
        state_nxt    = S_CHECK;
      end
      S_CHECK: begin
        if (stat.hit) begin
          cmd.set_hit = 1'b1;
          state_nxt   = S_FIN;
        end else if (stat.empty || stat.last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hdl/htpl_datapath.sv
// ----------------------------------------------------------------------------
// htpl_datapath: table storage and probe logic
// Key and value memories, per-slot valid bits, the probe index and count,
// the key compare and the output registers.
// ----------------------------------------------------------------------------
module htpl_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_mode,
  input  logic [6:0]           in_slot,
  input  logic [31:0]          in_key,
  input  logic [31:0]          in_entry_value,
  input  htpl_pkg::htpl_cmd_t  cmd,
  output htpl_pkg::htpl_stat_t stat,
  output logic                 out_found,
  output logic [31:0]          out_result_value,
  output logic [7:0]           out_probe_count
);
  import htpl_pkg::*;

  localparam logic [31:0]      MASK32   = 32'(SLOTS - 1);
  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(SLOTS - 1);

  logic [31:0]      keys_r  [SLOTS];
  logic [31:0]      vals_r  [SLOTS];
  logic [SLOTS-1:0] valid_r;

  logic [31:0]      key_r;
  logic [IDX_W-1:0] idx_r;
  logic [CNT_W-1:0] cnt_r;
  logic [31:0]      rd_key_r;
  logic [31:0]      rd_val_r;
  logic             rd_valid_r;
  logic             hit_r;
  logic [31:0]      hit_val_r;

  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] home_idx;
  logic             do_write;
  logic [31:0]      wr_mask32;
  logic [31:0]      home_mask32;
  logic [7:0]       cnt_sat;

  assign wr_mask32   = 32'(in_slot) & MASK32;
  assign home_mask32 = in_key & MASK32;
  assign wr_idx      = wr_mask32[IDX_W-1:0];
  assign home_idx    = home_mask32[IDX_W-1:0];
  assign do_write    = cmd.accept && (in_mode == MODE_STORE);

  // A slot whose valid bit is clear reads as an empty key.
  assign stat.in_find  = (in_mode == MODE_FIND);
  assign stat.key_zero = (in_key == 32'd0);
  assign stat.hit      = rd_valid_r && (rd_key_r == key_r);
  assign stat.empty    = !rd_valid_r || (rd_key_r == 32'd0);
  assign stat.last     = (cnt_r == CNT_W'(SLOTS));

  always_ff @(posedge clk) begin
    if (do_write) begin
      keys_r[wr_idx] <= in_key;
      vals_r[wr_idx] <= in_entry_value;
    end
    if (cmd.probe_rd) begin
      rd_key_r <= keys_r[idx_r];
      rd_val_r <= vals_r[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (do_write) begin
      valid_r[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe_rd) begin
      rd_valid_r <= valid_r[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      hit_r <= 1'b0;
    end else if (cmd.accept) begin
      cnt_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (cmd.probe_rd) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.set_hit) begin
        hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r <= in_key;
      idx_r <= home_idx;
    end else if (cmd.step) begin
      idx_r <= (idx_r - IDX_W'(1)) & IDX_MASK;
    end
    if (cmd.set_hit) begin
      hit_val_r <= rd_val_r;
    end
  end

  always_comb begin
    if (32'(cnt_r) > 32'd255) begin
      cnt_sat = 8'hFF;
    end else begin
      cnt_sat = 8'(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_found        <= hit_r;
      out_result_value <= hit_r ? hit_val_r : 32'd0;
      out_probe_count  <= cnt_sat;
    end
  end

endmodule

### hdl/hash_table_probe_lookup.sv
// ----------------------------------------------------------------------------
// hash_table_probe_lookup: open-addressed hash table with linear probing
// Stores key/value pairs by slot and finds keys by probing backwards from
// the key's home slot.
// ----------------------------------------------------------------------------
// A store or a find of key zero goes from the idle state straight to the
// final state, which loads the output registers; a find passes through a
// probe read and a check for each slot it examines. A new request is taken
// only in the idle state; each probe is one key memory read and one compare.
// Reset clears the controller, the output valid and all slot valid bits at
// once, so every slot reads as empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
module hash_table_probe_lookup (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [6:0]  in_slot,
  input  logic [31:0] in_key,
  input  logic [31:0] in_entry_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [31:0] out_result_value,
  output logic [7:0]  out_probe_count
);
  import htpl_pkg::*;

  // The controller walks each request through its steps; the datapath holds
  // the key and value memories, the valid bits and the probe counters.
  htpl_cmd_t  cmd;
  htpl_stat_t stat;

  // The controller takes a new request only when it is idle. The result
  // register in the datapath lets a finished result wait for the consumer
  // while the next request is already being worked on; a request only stalls
  // at its final step if the previous result has not yet been taken.
  htpl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // A store writes its slot in the cycle the request is taken. A find walks
  // backwards from key AND (SLOTS-1), stopping on a match, an empty slot, or
  // after every slot has been examined.
  htpl_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mode          (in_mode),
    .in_slot          (in_slot),
    .in_key           (in_key),
    .in_entry_value   (in_entry_value),
    .cmd              (cmd),
    .stat             (stat),
    .out_found        (out_found),
    .out_result_value (out_result_value),
    .out_probe_count  (out_probe_count)
  );

endmodule

### dv/hash_table_probe_lookup_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_table_probe_lookup_test: self-checking bench for the probe lookup
// A short directed sequence covers key zero, empty and wrapping probe chains,
// deleted slots and all-ones fields. Randomized episodes follow: they fill and
// wipe the table, insert keys along their probe chains, and look up stored,
// absent and zero keys. A scoreboard predicts each answer at request time and
// checks the answers in order, while both sides of the block idle at random.
// ----------------------------------------------------------------------------
module hash_table_probe_lookup_test;
  import htpl_pkg::*;

  localparam int ITEMS        = 1350;
  localparam int CALM_FROM    = 600;   // Requests between these two marks run
  localparam int CALM_UNTIL   = 900;   // with no idling on either side.
  localparam int IDLE_PCT     = 31;
  localparam int STALL_LIMIT  = 2000;  // Cycles with no request or answer moving.
  localparam int DRAIN_CYCLES = 16;

  // One answer of the block, as the scoreboard predicts it.
  typedef struct packed {
    logic        found;
    logic [31:0] value;
    logic [7:0]  probes;
  } answer_t;

  // The scoreboard keeps its own copy of both stores. Each accepted request
  // updates that copy and queues the answer it must produce; each answer that
  // leaves the block is compared with the oldest one queued.
  class probe_lookup_tracker;
    logic [31:0] slot_keys [SLOTS];
    logic [31:0] slot_values [SLOTS];
    answer_t     answers_due [$];
    int          mismatches;

    function new();
      foreach (slot_keys[i]) begin
        slot_keys[i]   = '0;
        slot_values[i] = '0;
      end
      mismatches = 0;
    endfunction

    function int home_slot(logic [31:0] key);
      return int'(key & 32'(SLOTS - 1));
    endfunction

    // Slot where a proper insert of the key lands: the first slot along its
    // probe chain that already holds it or is empty. -1 when there is none.
    function int insert_slot(logic [31:0] key);
      int idx;
      int n;
      idx = home_slot(key);
      for (n = 0; n < SLOTS; n++) begin
        if (slot_keys[idx] == key || slot_keys[idx] == '0) return idx;
        idx = (idx - 1) & (SLOTS - 1);
      end
      return -1;
    endfunction

    function void log_request(logic mode, logic [6:0] slot, logic [31:0] key,
                              logic [31:0] value);
      answer_t ans;
      int      idx;
      int      n;
      int      probes;
      ans    = '0;
      probes = 0;
      if (mode == MODE_STORE) begin
        idx = int'(slot) & (SLOTS - 1);
        slot_keys[idx]   = key;
        slot_values[idx] = value;
      end else if (key != '0) begin
        idx = home_slot(key);
        for (n = 0; n < SLOTS; n++) begin
          probes++;
          if (slot_keys[idx] == key) begin
            ans.found = 1'b1;
            ans.value = slot_values[idx];
            break;
          end
          if (slot_keys[idx] == '0) break;
          idx = (idx - 1) & (SLOTS - 1);
        end
      end
      ans.probes = (probes > 255) ? 8'd255 : 8'(probes);
      answers_due.push_back(ans);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("%0t ns: %s mismatch: got %0h, want %0h", $time, what, got, want);
    endtask

    task check_answer(logic found, logic [31:0] value, logic [7:0] probes);
      answer_t want;
      if (answers_due.size() == 0) begin
        report_mismatch("unrequested answer", value, '0);
      end else begin
        want = answers_due.pop_front();
        if (found !== want.found) report_mismatch("found", 32'(found), 32'(want.found));
        if (value !== want.value) report_mismatch("result_value", value, want.value);
        if (probes !== want.probes)
          report_mismatch("probe_count", 32'(probes), 32'(want.probes));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_ready;
  logic        in_mode          = MODE_STORE;
  logic [6:0]  in_slot          = '0;
  logic [31:0] in_key           = '0;
  logic [31:0] in_entry_value   = '0;
  logic        out_valid;
  logic        out_ready        = 1'b0;
  logic        out_found;
  logic [31:0] out_result_value;
  logic [7:0]  out_probe_count;

  probe_lookup_tracker book = new();
  int          requests_sent = 0;
  int          stall_cycles  = 0;
  bit          calm          = 1'b0;
  logic [31:0] stored_keys [$];

  hash_table_probe_lookup uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_slot          (in_slot),
    .in_key           (in_key),
    .in_entry_value   (in_entry_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_result_value (out_result_value),
    .out_probe_count  (out_probe_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The result side stalls at random, except inside the calm window.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Answers are sampled at the edge that takes them. The watchdog counts
  // cycles in which neither channel moves a request or an answer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (rst_n && out_valid && out_ready) begin
      book.check_answer(out_found, out_result_value, out_probe_count);
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offers one request and returns once the block has taken it. Idle cycles
  // go in front of the request, so valid is never dropped while it waits.
  task automatic send_request(logic mode, logic [6:0] slot, logic [31:0] key,
                              logic [31:0] value);
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_slot        <= slot;
    in_key         <= key;
    in_entry_value <= value;
    do @(posedge clk); while (!in_ready);
    book.log_request(mode, slot, key, value);
    requests_sent++;
    calm = (requests_sent >= CALM_FROM) && (requests_sent < CALM_UNTIL);
  endtask

  task automatic store_entry(int slot, logic [31:0] key, logic [31:0] value);
    send_request(MODE_STORE, 7'(slot), key, value);
  endtask

  // The slot and value fields mean nothing to a find, so they carry noise.
  task automatic find_key(logic [31:0] key);
    send_request(MODE_FIND, 7'($urandom()), key, $urandom());
  endtask

  // A random nonzero key whose probe chain starts at the given slot.
  function automatic logic [31:0] key_at_home(int home);
    logic [31:0] k;
    k = ($urandom() & ~32'(SLOTS - 1)) | 32'(home);
    if (k == '0) k = 32'(SLOTS);
    return k;
  endfunction

  // Empties a run of consecutive slots, wrapping at the end of the table.
  task automatic wipe_run(int first, int count);
    int n;
    for (n = 0; n < count; n++) store_entry((first + n) % SLOTS, '0, $urandom());
  endtask

  // An episode works on a cluster of home slots so that probe chains grow
  // long and run into each other. Most requests are proper inserts and
  // lookups of keys stored earlier; the rest are misses, stray stores into
  // arbitrary slots, deletions and lookups of key zero.
  task automatic run_episode(int length);
    int          base;
    int          span;
    int          pick;
    int          s;
    logic [31:0] k;
    base = $urandom_range(0, SLOTS - 1);
    span = $urandom_range(1, 24);
    repeat (length) begin
      pick = $urandom_range(0, 99);
      k    = key_at_home((base + $urandom_range(0, span - 1)) % SLOTS);
      if (pick < 40) begin
        s = book.insert_slot(k);
        if (s >= 0) begin
          store_entry(s, k, $urandom());
          stored_keys.push_back(k);
          if (stored_keys.size() > 96) void'(stored_keys.pop_front());
        end else begin
          // Every slot is taken, so this lookup walks the whole table.
          find_key(k);
        end
      end else if (pick < 75 && stored_keys.size() > 0) begin
        find_key(stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
      end else if (pick < 87) begin
        find_key(k);
      end else if (pick < 93) begin
        store_entry($urandom_range(0, SLOTS - 1), $urandom(), $urandom());
      end else if (pick < 97) begin
        store_entry($urandom_range(0, SLOTS - 1), '0, $urandom());
      end else begin
        find_key('0);
      end
    end
  endtask

  initial begin
    int          s;
    logic [31:0] k;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Keys ending in 0x05 share home slot 5; keys ending in
    // 0x00 share home slot 0 and their chains wrap to the top of the table.
    find_key('0);                                      // zero key, no probe
    find_key(32'h8000_0005);                           // empty table
    store_entry(5, 32'hFFFF_FF85, 32'hFFFF_FFFF);
    find_key(32'hFFFF_FF85);                           // hit at home
    store_entry(4, 32'h0000_0085, 32'h0000_0000);
    find_key(32'h0000_0085);                           // hit one slot down
    find_key(32'h8000_0005);                           // miss at empty slot 3
    store_entry(0, 32'hABCD_EF80, 32'h0000_0001);
    store_entry(127, 32'h1000_0000, 32'h8000_0000);
    find_key(32'h1000_0000);                           // hit after wrapping
    find_key(32'h2000_0000);                           // miss after wrapping
    store_entry(5, '0, 32'hDEAD_BEEF);                 // zero key empties slot 5
    find_key(32'hFFFF_FF85);                           // deleted key is gone
    find_key(32'h0000_0085);                           // chain cut by the hole
    store_entry(127, 32'hFFFF_FFFF, 32'hFFFF_FFFF);    // all fields at maximum
    find_key(32'hFFFF_FFFF);
    find_key(32'h1000_0000);                           // overwritten slot
    find_key(32'h0000_0001);

    // Full table: every slot holds a nonzero key, so absent keys are only
    // given up on after probing all of them.
    for (s = 0; s < SLOTS; s++) begin
      k = $urandom();
      if (k == '0) k = 32'h1;
      store_entry(s, k, $urandom());
      stored_keys.push_back(k);
      if (stored_keys.size() > 96) void'(stored_keys.pop_front());
    end
    repeat (4) find_key($urandom());
    repeat (4) find_key(stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
    wipe_run(0, SLOTS);

    // Random episodes, now and then clearing part of the table first so that
    // it keeps passing between sparse and crowded.
    while (requests_sent < ITEMS) begin
      if ($urandom_range(0, 3) == 0) wipe_run($urandom_range(0, SLOTS - 1),
                                              $urandom_range(16, SLOTS));
      run_episode($urandom_range(30, 90));
    end
    in_valid <= 1'b0;

    while (book.answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.mismatches == 0 && book.answers_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
